// ===== src/tsq_pkg.sv =====
package tsq_pkg;

   localparam int ADDR_IN_W = 12;
   localparam int ACC_W     = 10;
   localparam int ACC_MAX   = 511;
   localparam int FREQ_W    = 11;

   localparam logic [2:0] OP_FRAME   = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_START_M = 3'd2;
   localparam logic [2:0] OP_START_E = 3'd3;
   localparam logic [2:0] OP_STOP_A  = 3'd4;
   localparam logic [2:0] OP_STOP_M  = 3'd5;

   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_DATA_OK  = 2'd1;
   localparam logic [1:0] CSR_TICK_NUM = 2'd2;
   localparam logic [1:0] CSR_TICK_DEN = 2'd3;

   localparam logic VOICE_MUSIC  = 1'b0;
   localparam logic VOICE_EFFECT = 1'b1;

   localparam logic [15:0] PITCH_MUL  = 16'd212;
   localparam logic [15:0] PITCH_RND  = 16'd128;
   localparam logic [10:0] PITCH_BASE = 11'd5;

   typedef struct packed {
      logic             voice;
      logic             halt;
      logic [FREQ_W-1:0] freq;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       flush;
      logic       voice;
      logic [7:0] tens;
   } out_ctl_type;

   typedef struct packed {
      logic can_push;
      logic flush_done;
   } out_sts_type;

   // tens*5 + round(tens*212/256); zero tens gives zero
   function automatic logic [FREQ_W-1:0] freq_of(input logic [7:0] tens);
      logic [15:0]       prod;
      logic [FREQ_W-1:0] base;
      prod = 16'(tens) * PITCH_MUL + PITCH_RND;
      base = 11'(tens) * PITCH_BASE;
      return base + 11'(prod[15:8]);
   endfunction

endpackage

// ===== src/two_voice_tone_sequencer.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  opcode, frame_level, load_address, load_byte,
//                                             start_offset
// rsp       out        rsp_valid / rsp_ready  voice, halt, freq_value, last
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// One request at a time: it is accepted in idle, its address is reduced by R subtractions
// of SCORE_BYTES (R = 4096 / SCORE_BYTES at most, zero when SCORE_BYTES >= 4096), then it
// executes and finishes; stop all also pushes for the effect voice. A frame edge adds up to
// MAX_TICKS_PER_FRAME ticks, served through the single score memory port (duration read,
// loop-head read, pitch read per voice). Reset is synchronous; score memory is not cleared.
// A result waiting in the output register does not block the next request; a full
// output stage stalls the sequencer until rsp_ready.
module two_voice_tone_sequencer
   import tsq_pkg::*;
#(
   parameter int SCORE_BYTES         = 4096,
   parameter int MAX_TICKS_PER_FRAME = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   input  logic                 req_frame_level,
   input  logic [ADDR_IN_W-1:0] req_load_address,
   input  logic [7:0]           req_load_byte,
   input  logic [ADDR_IN_W-1:0] req_start_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_voice,
   output logic                 rsp_halt,
   output logic [FREQ_W-1:0]    rsp_freq_value,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_write_data
);

   localparam int ADDR_W = $clog2(SCORE_BYTES);
   localparam int TICK_W = $clog2(MAX_TICKS_PER_FRAME + 1);
   localparam logic [ADDR_W:0]    SB_EXT   = (ADDR_W + 1)'(SCORE_BYTES);
   localparam logic [ADDR_IN_W-1:0] RED_STEP = ADDR_IN_W'(SCORE_BYTES);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_REDUCE  = 4'd1;
   localparam logic [3:0] S_EXEC    = 4'd2;
   localparam logic [3:0] S_STOP2   = 4'd3;
   localparam logic [3:0] S_LOOP    = 4'd4;
   localparam logic [3:0] S_MUSIC   = 4'd5;
   localparam logic [3:0] S_M_DUR   = 4'd6;
   localparam logic [3:0] S_M_HEAD  = 4'd7;
   localparam logic [3:0] S_M_PITCH = 4'd8;
   localparam logic [3:0] S_EFFECT  = 4'd9;
   localparam logic [3:0] S_E_DUR   = 4'd10;
   localparam logic [3:0] S_E_PITCH = 4'd11;
   localparam logic [3:0] S_FINISH  = 4'd12;

   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [1:0] inc);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + (ADDR_W + 1)'(inc);
      if (s >= SB_EXT) begin
         s = s - SB_EXT;
      end
      return s[ADDR_W-1:0];
   endfunction

   logic [3:0]           state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic                 level_ff, level_in;
   logic [ADDR_IN_W-1:0] red_ff, red_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 prev_ff, prev_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic [ADDR_W-1:0]    mptr_ff, mptr_in;
   logic [ADDR_W-1:0]    mhead_ff, mhead_in;
   logic [ADDR_W-1:0]    eptr_ff, eptr_in;
   logic                 ma_ff, ma_in;
   logic                 ea_ff, ea_in;
   logic [7:0]           mrem_ff, mrem_in;
   logic [7:0]           erem_ff, erem_in;
   logic                 enable_ff, enable_in;
   logic                 data_ok_ff, data_ok_in;
   logic [7:0]           tick_num_ff, tick_num_in;
   logic [7:0]           tick_den_ff, tick_den_in;

   logic                 ram_wr, ram_rd;
   logic [ADDR_W-1:0]    ram_addr;
   logic [7:0]           ram_rdata;
   logic [ADDR_W-1:0]    addr_red;
   logic [7:0]           m_dec, e_dec;
   logic                 accept;
   out_ctl_type          octl;
   out_sts_type          osts;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign addr_red  = ADDR_W'(red_ff);
   assign m_dec     = (mrem_ff != 8'd0) ? mrem_ff - 8'd1 : 8'd0;
   assign e_dec     = (erem_ff != 8'd0) ? erem_ff - 8'd1 : 8'd0;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      level_in    = level_ff;
      red_in      = red_ff;
      byte_in     = byte_ff;
      prev_in     = prev_ff;
      acc_in      = acc_ff;
      ticks_in    = ticks_ff;
      mptr_in     = mptr_ff;
      mhead_in    = mhead_ff;
      eptr_in     = eptr_ff;
      ma_in       = ma_ff;
      ea_in       = ea_ff;
      mrem_in     = mrem_ff;
      erem_in     = erem_ff;
      enable_in   = enable_ff;
      data_ok_in  = data_ok_ff;
      tick_num_in = tick_num_ff;
      tick_den_in = tick_den_ff;
      ram_wr      = 1'b0;
      ram_rd      = 1'b0;
      ram_addr    = mptr_ff;
      octl.push   = 1'b0;
      octl.flush  = 1'b0;
      octl.voice  = VOICE_MUSIC;
      octl.tens   = 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               level_in = req_frame_level;
               byte_in  = req_load_byte;
               red_in   = (req_opcode == OP_LOAD) ? req_load_address : req_start_offset;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (32'(red_ff) >= SCORE_BYTES) begin
               red_in = red_ff - RED_STEP;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            unique case (op_ff)
               OP_FRAME: begin
                  if (enable_ff && (ma_ff || ea_ff)) begin
                     prev_in = level_ff;
                     if (level_ff && !prev_ff) begin
                        acc_in   = acc_ff + ACC_W'(tick_num_ff);
                        ticks_in = '0;
                        state_in = S_LOOP;
                     end
                  end
               end
               OP_LOAD: begin
                  ram_wr   = 1'b1;
                  ram_addr = addr_red;
               end
               OP_START_M: begin
                  if (!enable_ff || !data_ok_ff) begin
                     octl.push  = 1'b1;
                     octl.voice = VOICE_MUSIC;
                     ma_in      = 1'b0;
                     if (!osts.can_push) begin
                        state_in = S_EXEC;
                     end
                  end else begin
                     mhead_in = addr_red;
                     mptr_in  = addr_red;
                     ma_in    = 1'b1;
                     mrem_in  = 8'd0;
                     acc_in   = '0;
                  end
               end
               OP_START_E: begin
                  if (enable_ff && data_ok_ff) begin
                     eptr_in = addr_red;
                     ea_in   = 1'b1;
                     erem_in = 8'd0;
                  end
               end
               OP_STOP_A: begin
                  octl.push  = 1'b1;
                  octl.voice = VOICE_MUSIC;
                  ma_in      = 1'b0;
                  ea_in      = 1'b0;
                  state_in   = osts.can_push ? S_STOP2 : S_EXEC;
               end
               OP_STOP_M: begin
                  octl.push  = 1'b1;
                  octl.voice = VOICE_MUSIC;
                  ma_in      = 1'b0;
                  if (!osts.can_push) begin
                     state_in = S_EXEC;
                  end
               end
               default: begin
               end
            endcase
         end
         S_STOP2: begin
            octl.push  = 1'b1;
            octl.voice = VOICE_EFFECT;
            if (osts.can_push) begin
               state_in = S_FINISH;
            end
         end
         S_LOOP: begin
            if (ticks_ff < TICK_W'(MAX_TICKS_PER_FRAME) && acc_ff >= ACC_W'(tick_den_ff)) begin
               acc_in   = acc_ff - ACC_W'(tick_den_ff);
               ticks_in = ticks_ff + TICK_W'(1);
               state_in = S_MUSIC;
            end else begin
               if (acc_ff > ACC_W'(ACC_MAX)) begin
                  acc_in = ACC_W'(ACC_MAX);
               end
               state_in = S_FINISH;
            end
         end
         S_MUSIC: begin
            state_in = S_EFFECT;
            if (ma_ff) begin
               mrem_in = m_dec;
               if (m_dec == 8'd0) begin
                  ram_rd   = 1'b1;
                  ram_addr = mptr_ff;
                  state_in = S_M_DUR;
               end
            end
         end
         S_M_DUR: begin
            ram_rd = 1'b1;
            if (ram_rdata == 8'd0) begin
               mptr_in  = mhead_ff;
               ram_addr = mhead_ff;
               state_in = S_M_HEAD;
            end else begin
               mrem_in  = ram_rdata;
               ram_addr = wrap_add(mptr_ff, 2'd1);
               state_in = S_M_PITCH;
            end
         end
         S_M_HEAD: begin
            if (ram_rdata == 8'd0) begin
               // track is empty: music stops and the effect voice sits out this tick
               octl.push  = 1'b1;
               octl.voice = VOICE_MUSIC;
               if (osts.can_push) begin
                  ma_in    = 1'b0;
                  state_in = S_LOOP;
               end
            end else begin
               mrem_in  = ram_rdata;
               ram_rd   = 1'b1;
               ram_addr = wrap_add(mptr_ff, 2'd1);
               state_in = S_M_PITCH;
            end
         end
         S_M_PITCH: begin
            octl.push  = 1'b1;
            octl.voice = VOICE_MUSIC;
            octl.tens  = ram_rdata;
            if (osts.can_push) begin
               mptr_in  = wrap_add(mptr_ff, 2'd2);
               state_in = S_EFFECT;
            end
         end
         S_EFFECT: begin
            state_in = S_LOOP;
            if (ea_ff) begin
               erem_in = e_dec;
               if (e_dec == 8'd0) begin
                  ram_rd   = 1'b1;
                  ram_addr = eptr_ff;
                  state_in = S_E_DUR;
               end
            end
         end
         S_E_DUR: begin
            if (ram_rdata == 8'd0) begin
               octl.push  = 1'b1;
               octl.voice = VOICE_EFFECT;
               if (osts.can_push) begin
                  ea_in    = 1'b0;
                  state_in = S_LOOP;
               end
            end else begin
               erem_in  = ram_rdata;
               ram_rd   = 1'b1;
               ram_addr = wrap_add(eptr_ff, 2'd1);
               state_in = S_E_PITCH;
            end
         end
         S_E_PITCH: begin
            octl.push  = 1'b1;
            octl.voice = VOICE_EFFECT;
            octl.tens  = ram_rdata;
            if (osts.can_push) begin
               eptr_in  = wrap_add(eptr_ff, 2'd2);
               state_in = S_LOOP;
            end
         end
         S_FINISH: begin
            octl.flush = 1'b1;
            if (osts.flush_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_write_data[0];
               if (!csr_write_data[0]) begin
                  ma_in = 1'b0;
                  ea_in = 1'b0;
               end
            end
            CSR_DATA_OK:  data_ok_in  = csr_write_data[0];
            CSR_TICK_NUM: tick_num_in = csr_write_data;
            CSR_TICK_DEN: tick_den_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         prev_ff     <= 1'b0;
         acc_ff      <= '0;
         ticks_ff    <= '0;
         mptr_ff     <= '0;
         mhead_ff    <= '0;
         eptr_ff     <= '0;
         ma_ff       <= 1'b0;
         ea_ff       <= 1'b0;
         mrem_ff     <= 8'd0;
         erem_ff     <= 8'd0;
         enable_ff   <= 1'b1;
         data_ok_ff  <= 1'b0;
         tick_num_ff <= 8'd1;
         tick_den_ff <= 8'd1;
      end else begin
         state_ff    <= state_in;
         prev_ff     <= prev_in;
         acc_ff      <= acc_in;
         ticks_ff    <= ticks_in;
         mptr_ff     <= mptr_in;
         mhead_ff    <= mhead_in;
         eptr_ff     <= eptr_in;
         ma_ff       <= ma_in;
         ea_ff       <= ea_in;
         mrem_ff     <= mrem_in;
         erem_ff     <= erem_in;
         enable_ff   <= enable_in;
         data_ok_ff  <= data_ok_in;
         tick_num_ff <= tick_num_in;
         tick_den_ff <= tick_den_in;
      end
      op_ff    <= op_in;
      level_ff <= level_in;
      red_ff   <= red_in;
      byte_ff  <= byte_in;
   end

   tsq_ram #(
      .WIDTH (8),
      .DEPTH (SCORE_BYTES)
   ) u_score (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (ram_addr),
      .wr_data (byte_ff),
      .rd_data (ram_rdata)
   );

   tsq_out u_out (
      .clock          (clock),
      .reset          (reset),
      .ctl            (octl),
      .sts            (osts),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_voice      (rsp_voice),
      .rsp_halt       (rsp_halt),
      .rsp_freq_value (rsp_freq_value),
      .rsp_last       (rsp_last)
   );

   a_acc_saturated: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> acc_ff <= ACC_W'(ACC_MAX))
      else $error("tempo accumulator above saturation limit while idle");

   a_tick_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUSIC |-> ticks_ff <= TICK_W'(MAX_TICKS_PER_FRAME) && ticks_ff != '0)
      else $error("tick count outside frame cap");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(mptr_ff) < SCORE_BYTES && 32'(mhead_ff) < SCORE_BYTES && 32'(eptr_ff) < SCORE_BYTES)
      else $error("score pointer beyond memory");

   a_ram_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_wr && !ram_rd && !octl.push)
      else $error("memory or result activity while idle");

endmodule

// ===== src/tsq_ram.sv =====
module tsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tsq_out.sv =====
module tsq_out
   import tsq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  out_ctl_type       ctl,
   output out_sts_type       sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_voice,
   output logic              rsp_halt,
   output logic [FREQ_W-1:0] rsp_freq_value,
   output logic              rsp_last
);

   // one held result: its last flag is known only when the next one arrives or the request ends
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    last_ff, last_in;
   rsp_type item;
   logic    out_free;

   assign out_free       = !out_valid_ff || rsp_ready;
   assign sts.can_push   = !pend_valid_ff || out_free;
   assign sts.flush_done = !pend_valid_ff || out_free;

   always_comb begin
      item.voice    = ctl.voice;
      item.halt     = (ctl.tens == 8'd0);
      item.freq     = freq_of(ctl.tens);
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      last_in       = last_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (ctl.push && sts.can_push) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            last_in      = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = item;
         pend_valid_in = 1'b1;
      end else if (ctl.flush && pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         last_in       = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_voice      = out_ff.voice;
   assign rsp_halt       = out_ff.halt;
   assign rsp_freq_value = out_ff.freq;
   assign rsp_last       = last_ff;

endmodule
